// ===== src/assert_macros.svh =====
// Assertion helper macros for the keystream block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Overlapping implication under clock and reset.
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication under clock and reset.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== src/cks_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cks_pkg: shared constants for the ChaCha keystream block
// Widths, lane count, register indexes and a rotate-left helper.
// ----------------------------------------------------------------------------
package cks_pkg;
  localparam int unsigned Lanes     = 8;
  localparam int unsigned LaneW     = $clog2(Lanes) > 0 ? $clog2(Lanes) : 1;
  localparam int unsigned Words     = 16;
  localparam int unsigned OutWords  = Lanes * 8;
  localparam int unsigned IdxW      = 6;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned RamDepth  = Lanes * Words;
  localparam int unsigned RamAddrW  = $clog2(RamDepth);

  typedef enum logic [CfgIdxW-1:0] {
    RegC01 = 3'd0, RegC23 = 3'd1, RegK45 = 3'd2, RegK67 = 3'd3,
    RegK89 = 3'd4, RegKab = 3'd5, RegNonce = 3'd6, RegRounds = 3'd7
  } cfg_reg_e;

  function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned n);
    rotl = (x << n) | (x >> (32 - n));
  endfunction
endpackage
`default_nettype wire

// ===== src/chacha_keystream_8block.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// chacha_keystream_8block: ChaCha keystream, eight blocks per transaction
// Working state of all lanes lives in one RAM; a quarter-round unit reads
// four words, computes, and writes them back; results stream out of RAM.
// ----------------------------------------------------------------------------
//  channel  | signals                               | dir
//  request  | req_valid_i/req_ready_o, cmd, counter | in
//  keystream| ks_valid_o/ks_ready_i, word, idx, last| out
//  config   | cfg_we_i, cfg_idx_i, cfg_data_i       | in
//
// Sequence: per lane 16 loaded words + 8*dbl quarter-rounds (5 read steps,
// compute, 4 writes) + 8 output words (read lo, read hi, emit); one RAM paces.
// Requests are taken only when idle with the output register empty.
// Output stalls hold the sequencer; a stalled word rereads both halves.
// Reset clears the counter and config but sets rounds to 20; RAM needs no
// reset as every word is written before it is read.
// ----------------------------------------------------------------------------
module chacha_keystream_8block (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [cks_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [63:0] cfg_data_i,
  input  wire logic        req_valid_i,
  output logic             req_ready_o,
  input  wire logic        cmd_i,
  input  wire logic [63:0] counter_value_i,
  output logic             ks_valid_o,
  input  wire logic        ks_ready_i,
  output logic [63:0]      keystream_word_o,
  output logic [cks_pkg::IdxW-1:0] word_index_o,
  output logic             last_o
);
  import cks_pkg::*;

  typedef enum logic [2:0] {SIdle, SLoad, SRead, SCalc, SWrite, SOut} state_e;

  logic [63:0] cfg_q [7];
  logic [4:0]  rounds_q;
  logic [63:0] ctr_q, lctr_q;
  state_e      state_q;
  logic [LaneW-1:0] lane_q;
  logic [3:0]  widx_q;     // word index for load and out word
  logic [3:0]  dbl_q;
  logic [2:0]  qr_q;       // quarter-round within double round
  logic [2:0]  step_q;     // sub-step of read/write/out
  logic [31:0] qv_q [4];
  logic        ram_we;
  logic [RamAddrW-1:0] ram_wa, ram_ra;
  logic [31:0] ram_wd, ram_rd;
  logic [31:0] lo_q;
  logic        out_full_q;
  logic        emit;

  cks_ram #(.Width(32), .Depth(RamDepth)) u_ram (
    .clk_i, .we_i(ram_we), .waddr_i(ram_wa), .wdata_i(ram_wd),
    .raddr_i(ram_ra), .rdata_o(ram_rd));

  // initial state word w for current lane
  function automatic logic [31:0] init_word(input logic [3:0] w);
    logic [63:0] r;
    r = (w < 4'd12) ? cfg_q[w[3:1]] : (w < 4'd14) ? lctr_q : cfg_q[RegNonce];
    init_word = w[0] ? r[63:32] : r[31:0];
  endfunction

  // word indexes of quarter-round qr
  function automatic logic [3:0] qidx(input logic [2:0] qr, input logic [1:0] k);
    logic [1:0] c;
    c = qr[1:0] + (qr[2] ? 2'(k) : 2'd0);
    qidx = {k, (k == 2'd0) ? qr[1:0] : c};
  endfunction

  logic [31:0] a1, d1, c1, b1, a2, d2, c2, b2;
  always_comb begin
    a1 = qv_q[0] + qv_q[1]; d1 = rotl(qv_q[3] ^ a1, 16);
    c1 = qv_q[2] + d1;      b1 = rotl(qv_q[1] ^ c1, 12);
    a2 = a1 + b1;           d2 = rotl(d1 ^ a2, 8);
    c2 = c1 + d2;           b2 = rotl(b1 ^ c2, 7);
  end

  logic [RamAddrW-1:0] base;
  assign base = RamAddrW'({lane_q, 4'd0});

  always_comb begin
    ram_we = 1'b0; ram_wa = base; ram_wd = '0; ram_ra = base;
    case (state_q)
      SLoad: begin
        ram_we = 1'b1; ram_wa = base | RamAddrW'(widx_q); ram_wd = init_word(widx_q);
      end
      SRead: ram_ra = base | RamAddrW'(qidx(qr_q, step_q[1:0]));
      SWrite: begin
        ram_we = 1'b1; ram_wa = base | RamAddrW'(qidx(qr_q, step_q[1:0]));
        ram_wd = qv_q[step_q[1:0]];
      end
      SOut: ram_ra = base | RamAddrW'({widx_q[2:0], step_q[0]});
      default: ;
    endcase
  end

  assign req_ready_o = (state_q == SIdle) && !out_full_q;
  assign ks_valid_o  = out_full_q;
  // output register loads when the hi word is in and the slot frees up
  assign emit = (state_q == SOut) && (step_q == 3'd2) && (!out_full_q || ks_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 7; i++) cfg_q[i] <= '0;
      rounds_q <= 5'd20; ctr_q <= '0; lctr_q <= '0; state_q <= SIdle;
      lane_q <= '0; widx_q <= '0; dbl_q <= '0; qr_q <= '0; step_q <= '0;
      out_full_q <= 1'b0; lo_q <= '0;
      for (int i = 0; i < 4; i++) qv_q[i] <= '0;
      keystream_word_o <= '0; word_index_o <= '0; last_o <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == RegRounds) rounds_q <= cfg_data_i[4:0];
        else cfg_q[cfg_idx_i] <= cfg_data_i;
      end
      if (emit) out_full_q <= 1'b1;
      else if (out_full_q && ks_ready_i) out_full_q <= 1'b0;
      case (state_q)
        SIdle: if (req_valid_i && req_ready_o) begin
          lctr_q <= cmd_i ? counter_value_i : ctr_q;
          ctr_q  <= (cmd_i ? counter_value_i : ctr_q) + 64'(Lanes);
          lane_q <= '0; widx_q <= '0; state_q <= SLoad;
        end
        SLoad: begin
          if (widx_q == 4'd15) begin
            dbl_q <= '0; qr_q <= '0; step_q <= '0;
            state_q <= (rounds_q[4:1] == 4'd0) ? SOut : SRead;
            widx_q <= '0;
          end else widx_q <= widx_q + 4'd1;
        end
        SRead: begin
          // data of read step k-1 arrives at step k
          if (step_q != 3'd0) qv_q[step_q[1:0] - 2'd1] <= ram_rd;
          step_q <= step_q + 3'd1;
          if (step_q == 3'd4) state_q <= SCalc;
        end
        SCalc: begin
          qv_q[0] <= a2; qv_q[1] <= b2; qv_q[2] <= c2; qv_q[3] <= d2;
          step_q <= '0; state_q <= SWrite;
        end
        SWrite: begin
          if (step_q == 3'd3) begin
            step_q <= '0; qr_q <= qr_q + 3'd1;
            if (qr_q == 3'd7) dbl_q <= dbl_q + 4'd1;
            if (qr_q == 3'd7 && dbl_q + 4'd1 == rounds_q[4:1]) state_q <= SOut;
            else state_q <= SRead;
          end else step_q <= step_q + 3'd1;
        end
        SOut: begin
          // step0: read lo, step1: read hi / latch lo, step2: emit
          if (step_q == 3'd0) step_q <= 3'd1;
          else if (step_q == 3'd1) begin
            lo_q <= ram_rd + init_word({widx_q[2:0], 1'b0}); step_q <= 3'd2;
          end else if (emit) begin
            keystream_word_o <= {ram_rd + init_word({widx_q[2:0], 1'b1}), lo_q};
            word_index_o <= IdxW'({lane_q, widx_q[2:0]});
            last_o <= (lane_q == LaneW'(Lanes - 1)) && (widx_q[2:0] == 3'd7);
            step_q <= '0;
            if (widx_q[2:0] == 3'd7) begin
              widx_q <= '0;
              if (lane_q == LaneW'(Lanes - 1)) state_q <= SIdle;
              else begin
                lane_q <= lane_q + LaneW'(1); lctr_q <= lctr_q + 64'd1; state_q <= SLoad;
              end
            end else widx_q <= widx_q + 4'd1;
          end else step_q <= 3'd0; // hi word lost while stalled: reread
        end
        default: state_q <= SIdle;
      endcase
    end
  end

  `include "assert_macros.svh"
  `ASSERT_IMPL(a_ready_idle, req_ready_o, state_q == SIdle)
  `ASSERT_NEXT(a_accept_load, req_valid_i && req_ready_o, state_q == SLoad)
  `ASSERT_IMPL(a_last_idx, ks_valid_o && last_o, word_index_o == IdxW'(OutWords - 1))
endmodule
`default_nettype wire

// ===== src/cks_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cks_ram: generic simple dual-port RAM (one write port, one read port)
// One write and one read per cycle, registered read data.
// ----------------------------------------------------------------------------
module cks_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire
